// ----- hw/rtl/eafr_pkg.sv -----
// ----------------------------------------------------------------------------
// eafr_pkg - shared types and constants for the escaped API frame receiver
// Frame phases, framing byte codes, status codes and the result beat type.
// ----------------------------------------------------------------------------
package eafr_pkg;

  // Framing bytes
  localparam logic [7:0] DELIM_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE    = 8'h7D;
  localparam logic [7:0] ESC_XOR     = 8'h20;
  localparam logic [7:0] CSUM_TARGET = 8'hFF;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_START = 2'd1;

  // Reset values of the configuration registers
  localparam logic       ESCAPE_ENABLE_RST = 1'b1;
  localparam logic [7:0] PAYLOAD_START_RST = 8'd15;

  // Frame status codes
  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_BAD_CSUM = 2'd1;
  localparam logic [1:0] ST_ABORTED  = 2'd2;
  localparam logic [1:0] ST_OVERSIZE = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_DATA   = 3'd3,
    PH_CSUM   = 3'd4
  } eafr_phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic [1:0] frame_status;
    logic       last;
  } eafr_res_t;

endpackage

// ----- hw/rtl/eafr_parser.sv -----
// ----------------------------------------------------------------------------
// eafr_parser - frame state machine
// Unescapes each accepted byte, tracks length, position and checksum, and
// produces at most one result beat for it in the same cycle.
// ----------------------------------------------------------------------------
module eafr_parser
  import eafr_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       escape_enable,
  input  logic [7:0] payload_start,
  output logic       res_valid,
  output eafr_res_t  res
);

  localparam logic [15:0] MaxLen = 16'(MAX_FRAME_LEN);

  eafr_phase_t phase_r, phase_nxt;
  logic        esc_pend_r, esc_pend_nxt;
  logic [16:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  sum_r, sum_nxt;

  logic [7:0]  v;
  logic        go;
  logic [15:0] len_lo;
  logic [16:0] data_end;

  assign len_lo   = {len_r[15:8], v};
  assign data_end = 17'(len_r) + 17'd2;

  always_comb begin
    phase_nxt    = phase_r;
    esc_pend_nxt = esc_pend_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    sum_nxt      = sum_r;
    res_valid    = 1'b0;
    res          = '0;
    v            = rx_byte;
    go           = 1'b0;

    if (phase_r == PH_HUNT || phase_r > PH_CSUM) begin
      if (rx_byte == DELIM_BYTE) begin
        phase_nxt    = PH_LEN_HI;
        esc_pend_nxt = 1'b0;
        pos_nxt      = 17'd1;
        len_nxt      = '0;
        sum_nxt      = '0;
      end else begin
        phase_nxt = PH_HUNT;
      end
    end else if (escape_enable && rx_byte == DELIM_BYTE) begin
      // raw delimiter mid-frame: restart and report the abort
      phase_nxt        = PH_LEN_HI;
      esc_pend_nxt     = 1'b0;
      pos_nxt          = 17'd1;
      len_nxt          = '0;
      sum_nxt          = '0;
      res_valid        = 1'b1;
      res.is_status    = 1'b1;
      res.frame_status = ST_ABORTED;
      res.last         = 1'b1;
    end else begin
      if (esc_pend_r) begin
        esc_pend_nxt = 1'b0;
        v            = rx_byte ^ ESC_XOR;
        go           = 1'b1;
      end else if (escape_enable && rx_byte == ESC_BYTE) begin
        esc_pend_nxt = 1'b1;
      end else begin
        go = 1'b1;
      end
    end

    if (go) begin
      pos_nxt = pos_r + 17'd1;
      unique case (phase_r)
        PH_LEN_HI: begin
          len_nxt   = {v, 8'h00};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt = len_lo;
          if (len_lo > MaxLen) begin
            phase_nxt        = PH_HUNT;
            res_valid        = 1'b1;
            res.is_status    = 1'b1;
            res.frame_status = ST_OVERSIZE;
            res.last         = 1'b1;
          end else begin
            phase_nxt = (len_lo == '0) ? PH_CSUM : PH_DATA;
          end
        end
        PH_DATA: begin
          sum_nxt = sum_r + v;
          if (pos_r >= data_end) begin
            phase_nxt = PH_CSUM;
          end
          if (pos_r >= {9'd0, payload_start}) begin
            res_valid    = 1'b1;
            res.out_byte = v;
          end
        end
        default: begin
          // checksum byte closes the frame
          phase_nxt        = PH_HUNT;
          res_valid        = 1'b1;
          res.is_status    = 1'b1;
          res.frame_status = ((CSUM_TARGET - sum_r) == v) ? ST_GOOD : ST_BAD_CSUM;
          res.last         = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      esc_pend_r <= 1'b0;
      pos_r      <= '0;
      len_r      <= '0;
      sum_r      <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      esc_pend_r <= esc_pend_nxt;
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      sum_r      <= sum_nxt;
    end
  end

endmodule

// ----- hw/rtl/eafr_out_skid.sv -----
// ----------------------------------------------------------------------------
// eafr_out_skid - result register with skid stage
// Holds the output beat and one spare, so one result can load under stall.
// ----------------------------------------------------------------------------
module eafr_out_skid
  import eafr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  eafr_res_t load_res,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output eafr_res_t out_res
);

  logic      out_valid_r;
  eafr_res_t out_r;
  logic      skid_valid_r;
  eafr_res_t skid_r;
  logic      take;

  assign take      = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (load) begin
      if (out_valid_r && !take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (load) begin
      if (out_valid_r && !take) begin
        skid_r <= load_res;
      end else begin
        out_r <= load_res;
      end
    end
  end

endmodule

// ----- hw/rtl/escaped_api_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// escaped_api_frame_receiver - API frame receiver with byte escaping
// Parses delimited, length-prefixed, checksummed frames from a byte stream.
// ----------------------------------------------------------------------------
// One received byte is taken per beat and can be taken every cycle while
// in_stall is low. A result goes into the output register in the cycle
// after its input beat. If the output register is still held by out_stall,
// the result goes into the skid entry instead.
// A frame is 0x7E, length high, length low, data bytes, checksum. With
// escape_enable set, 0x7D drops out and flips bit 5 of the next byte, and a
// raw 0x7E inside a frame aborts it (status 2) and opens a new one. Data
// bytes at frame position >= payload_start (delimiter is position 0) come out
// as payload beats. The checksum byte closes the frame with a status beat
// (0 good, 1 bad checksum). A length above MAX_FRAME_LEN ends the frame early
// with status 3. Status beats carry last=1 and a zero byte.
// The result path is an output register plus one skid entry. in_stall is high
// while the skid entry is occupied, which lasts until the output beat is
// taken. When results come every cycle, out_stall stalls the input as well.
// With sparser results, a short out_stall need not stall the input.
// Config writes are always ready (cfg_ready tied high) and take effect on the
// next byte; write them only while the stream is idle.
// ----------------------------------------------------------------------------
module escaped_api_frame_receiver
  import eafr_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // received byte beats
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  // result beats
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_is_status,
  output logic [1:0]           out_frame_status,
  output logic                 out_last,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic       escape_enable_r;
  logic [7:0] payload_start_r;
  logic       accept;
  logic       res_valid;
  eafr_res_t  res;
  logic       skid_full;
  eafr_res_t  out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_enable_r <= ESCAPE_ENABLE_RST;
      payload_start_r <= PAYLOAD_START_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ESCAPE_ENABLE: escape_enable_r <= cfg_data[0];
        CFG_PAYLOAD_START: payload_start_r <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // Stall only when the spare result slot is occupied.
  assign in_stall = skid_full;
  assign accept   = in_valid && !in_stall;

  eafr_parser #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .rx_byte       (in_rx_byte),
    .escape_enable (escape_enable_r),
    .payload_start (payload_start_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  eafr_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept && res_valid),
    .load_res  (res),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte         = out_res.out_byte;
  assign out_is_status    = out_res.is_status;
  assign out_frame_status = out_res.frame_status;
  assign out_last         = out_res.last;

endmodule
